// ----- rtl/fpr_pkg.sv -----
// Shared types and constants for the FIFO page replacement block.
`default_nettype none
package fpr_pkg;
    localparam int CFG_W       = 5;
    localparam int PAGE_IN_W   = 16;
    localparam int SLOT_W      = 4;
    localparam int FAULT_W     = 16;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_USER_W  = 2;
    localparam int CFG_RESET   = 4;

    typedef struct packed {
        logic wr_en;
        logic clear;
    } t_cell_ctl;
endpackage
`default_nettype wire

// ----- rtl/fpr_cell.sv -----
// One frame cell: page register, valid bit, match and first-hit chain stage.
`default_nettype none
module fpr_cell
    import fpr_pkg::*;
#(
    parameter int PAGE_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [PAGE_BITS-1:0] i_key,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic                 i_active,
    input  wire logic                 i_hit_in,
    output logic                      o_hit_out,
    output logic                      o_first,
    output logic                      o_valid,
    output logic [PAGE_BITS-1:0]      o_page
);
    logic                 r_valid;
    logic [PAGE_BITS-1:0] r_page;
    logic                 n_valid;
    logic                 w_match;

    assign w_match   = i_active && r_valid && (r_page == i_key);
    assign o_first   = w_match && !i_hit_in;
    assign o_hit_out = i_hit_in || w_match;
    assign o_valid   = r_valid;
    assign o_page    = r_page;

    always_comb begin
        n_valid = r_valid || i_ctl.wr_en;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_ctl.wr_en) begin
            r_page <= i_key;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/fifo_page_replacement.sv -----
// Top level of the FIFO page replacement block.
// Usage:
//   Slave stream: i_s_tdata[15:0] is the page number, i_s_tlast marks the last
//   reference of a string; after that item the table, fault count and replace
//   pointer are cleared.
//   Master stream: one result per item. o_m_tuser[0] page fault,
//   o_m_tuser[1] evicted valid; o_m_tdata holds frame slot, evicted page and
//   fault total.
//   Config channel: i_cfg_data sets the active frame count (0 acts as 1,
//   above MAX_FRAMES acts as MAX_FRAMES); always ready, table kept.
// Timing:
//   Each item passes an accept state and a lookup state; in the lookup the
//   row of frame cells compares the page, the first-hit chain picks the
//   lowest matching frame and the cells update. The result sits in the output
//   register the cycle after the lookup. No new item is accepted during a lookup.
//   If the receiver stalls, the output register holds its item; the next item
//   is accepted but its lookup waits until the output register frees.
// Reset (synchronous, active low) clears all valid bits, the pointer, the
// fault count and sets the frame count to 4.
`default_nettype none
module fifo_page_replacement
    import fpr_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [PAGE_IN_W-1:0]  i_s_tdata,  // page_number
    input  wire logic                  i_s_tlast,  // last_reference
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,  // frame_slot, evicted_page, fault_total, pad
    output logic [OUT_USER_W-1:0]      o_m_tuser,  // page_fault, evicted_valid
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = 8;

    typedef enum logic {S_IDLE, S_LOOK} t_state;

    t_state                  r_state;
    logic [CFG_W-1:0]        r_frames;
    logic [PAGE_BITS-1:0]    r_key;
    logic                    r_last;
    logic [IDX_W-1:0]        r_ptr;
    logic [FAULT_W-1:0]      r_fault;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic [OUT_USER_W-1:0]   r_out_user;

    logic [31:0]             w_page_wide;
    logic [CNT_W-1:0]        w_cfg_ext;
    logic [CNT_W-1:0]        w_n;
    logic [CNT_W-1:0]        w_ptr_ext;
    logic [IDX_W-1:0]        w_p;
    logic [IDX_W-1:0]        n_ptr;
    logic [FAULT_W-1:0]      n_fault;
    logic                    w_hit;
    logic [IDX_W-1:0]        w_hit_slot;
    logic [IDX_W-1:0]        w_slot;
    logic                    w_ev_valid;
    logic [31:0]             w_ev_wide;
    logic                    w_load;
    logic                    w_take;

    logic [MAX_FRAMES:0]     w_chain;
    logic [MAX_FRAMES-1:0]   w_first;
    logic [MAX_FRAMES-1:0]   w_valid;
    logic [MAX_FRAMES-1:0]   w_active;
    logic [PAGE_BITS-1:0]    w_page [MAX_FRAMES];
    t_cell_ctl               w_ctl  [MAX_FRAMES];

    assign w_page_wide = {{(32 - PAGE_IN_W){1'b0}}, i_s_tdata};
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;

    always_comb begin
        w_cfg_ext = CNT_W'(r_frames);
        if (w_cfg_ext == '0) begin
            w_n = CNT_W'(1);
        end else if (w_cfg_ext > CNT_W'(MAX_FRAMES)) begin
            w_n = CNT_W'(MAX_FRAMES);
        end else begin
            w_n = w_cfg_ext;
        end
        w_ptr_ext = CNT_W'(r_ptr);
        w_p = (w_ptr_ext >= w_n) ? '0 : r_ptr;
        n_ptr = (CNT_W'(w_p) + CNT_W'(1) == w_n) ? '0 : IDX_W'(CNT_W'(w_p) + CNT_W'(1));
    end

    assign w_chain[0] = 1'b0;
    assign w_hit      = w_chain[MAX_FRAMES];
    assign w_take     = !r_out_valid || i_m_tready;
    assign w_load     = (r_state == S_LOOK) && w_take;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        assign w_active[g]     = (CNT_W'(g) < w_n);
        assign w_ctl[g].wr_en  = w_load && !w_hit && (w_p == IDX_W'(g));
        assign w_ctl[g].clear  = w_load && r_last;
        fpr_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_key     (r_key),
            .i_ctl     (w_ctl[g]),
            .i_active  (w_active[g]),
            .i_hit_in  (w_chain[g]),
            .o_hit_out (w_chain[g+1]),
            .o_first   (w_first[g]),
            .o_valid   (w_valid[g]),
            .o_page    (w_page[g])
        );
    end

    always_comb begin
        w_hit_slot = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (w_first[i]) begin
                w_hit_slot = w_hit_slot | IDX_W'(i);
            end
        end
        w_slot     = w_hit ? w_hit_slot : w_p;
        w_ev_valid = !w_hit && w_valid[w_p];
        w_ev_wide  = w_ev_valid ? 32'(w_page[w_p]) : '0;
        n_fault    = r_fault;
        if (!w_hit && (r_fault != '1)) begin
            n_fault = r_fault + FAULT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frames    <= CFG_W'(CFG_RESET);
            r_ptr       <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_frames <= i_cfg_data;
            end
            if (r_out_valid && i_m_tready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_key   <= w_page_wide[PAGE_BITS-1:0];
                        r_last  <= i_s_tlast;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (w_take) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= {w_ev_valid, !w_hit};
                        r_out_data  <= {{(OUT_DATA_W - SLOT_W - PAGE_IN_W - FAULT_W){1'b0}},
                                        n_fault, w_ev_wide[PAGE_IN_W-1:0],
                                        SLOT_W'(32'(w_slot))};
                        if (r_last) begin
                            r_ptr   <= '0;
                            r_fault <= '0;
                        end else begin
                            r_fault <= n_fault;
                            if (!w_hit) begin
                                r_ptr <= n_ptr;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first-hit cell");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_hit) |=> (o_m_tuser == '0))
        else $error("hit reported a fault or an eviction");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_last) |=> (r_fault == '0 && r_ptr == '0 && w_valid == '0))
        else $error("last reference did not clear the table");
endmodule
`default_nettype wire

// ----- tb/sv/tb_fifo_page_replacement.sv -----
// Testbench for fifo_page_replacement: directed and random page reference streams.
`timescale 1ns / 100ps

module tb_fifo_page_replacement;
    import fpr_pkg::*;

    localparam int NUM_FRAMES   = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [FAULT_W-1:0] FAULT_CEIL = '1;

    typedef struct packed {
        logic                 page_fault;
        logic [SLOT_W-1:0]    frame_slot;
        logic                 evicted_valid;
        logic [PAGE_IN_W-1:0] evicted_page;
        logic [FAULT_W-1:0]   fault_total;
    } t_lookup;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [PAGE_IN_W-1:0]  i_s_tdata   = '0;  // page_number
    logic                  i_s_tlast   = 1'b0;  // last_reference
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;  // frame_slot, evicted_page, fault_total, pad
    logic [OUT_USER_W-1:0] o_m_tuser;  // page_fault, evicted_valid
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data  = '0;

    fifo_page_replacement #(
        .MAX_FRAMES(NUM_FRAMES),
        .PAGE_BITS (16)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    logic [PAGE_IN_W-1:0] tbl_page  [NUM_FRAMES];
    bit                   tbl_valid [NUM_FRAMES];
    int unsigned          tbl_ptr    = 0;
    logic [FAULT_W-1:0]   tbl_faults = '0;
    logic [CFG_W-1:0]     tbl_frames = CFG_W'(CFG_RESET);

    t_lookup pending_lookups[$];
    bit      src_idle_en   = 1'b1;
    bit      sink_idle_en  = 1'b1;
    int      stall_left    = 0;
    int      cycle_count   = 0;
    int      mismatch_count = 0;
    int      refs_sent     = 0;
    int      results_seen  = 0;
    int      faults_seen   = 0;
    int      evictions_seen = 0;
    int      cfg_writes    = 0;

    always #5 i_clk = ~i_clk;

    function automatic t_lookup resolve_reference(input logic [PAGE_IN_W-1:0] pg, input bit is_last);
        int unsigned n;
        int unsigned p;
        bit          found;
        t_lookup     r;
        n = tbl_frames;
        if (n == 0) n = 1;
        if (n > NUM_FRAMES) n = NUM_FRAMES;
        r = '0;
        found = 1'b0;
        for (int i = 0; i < n && !found; i++) begin
            if (tbl_valid[i] && tbl_page[i] == pg) begin
                found = 1'b1;
                r.frame_slot = SLOT_W'(i);
            end
        end
        if (!found) begin
            p = tbl_ptr;
            if (p >= n) p = 0;
            if (tbl_valid[p]) begin
                r.evicted_valid = 1'b1;
                r.evicted_page  = tbl_page[p];
            end
            tbl_page[p]  = pg;
            tbl_valid[p] = 1'b1;
            r.frame_slot = SLOT_W'(p);
            r.page_fault = 1'b1;
            tbl_ptr = (p + 1) % n;
            if (tbl_faults != FAULT_CEIL) tbl_faults++;
        end
        r.fault_total = tbl_faults;
        if (is_last) begin
            foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            tbl_ptr    = 0;
            tbl_faults = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        $display("mismatch at result %0d: %s expected %0h got %0h",
                 results_seen, what, want, got);
    endtask

    task automatic send_reference(input logic [PAGE_IN_W-1:0] pg, input bit is_last);
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pg;
        i_s_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_lookups.push_back(resolve_reference(pg, is_last));
        refs_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame_count(input logic [CFG_W-1:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tbl_frames = val;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_lookup want;
        t_lookup got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser[0], o_m_tdata[3:0], o_m_tuser[1], o_m_tdata[19:4],
                   o_m_tdata[35:20]};
            if (pending_lookups.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", 0, o_m_tdata);
            end else begin
                want = pending_lookups.pop_front();
                if (got.page_fault != want.page_fault)
                    report_mismatch("page_fault", want.page_fault, got.page_fault);
                if (got.frame_slot != want.frame_slot)
                    report_mismatch("frame_slot", want.frame_slot, got.frame_slot);
                if (got.evicted_valid != want.evicted_valid)
                    report_mismatch("evicted_valid", want.evicted_valid, got.evicted_valid);
                if (got.evicted_page != want.evicted_page)
                    report_mismatch("evicted_page", want.evicted_page, got.evicted_page);
                if (got.fault_total != want.fault_total)
                    report_mismatch("fault_total", want.fault_total, got.fault_total);
                if (want.page_fault) faults_seen++;
                if (want.evicted_valid) evictions_seen++;
            end
            results_seen++;
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 18);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_lookups.size());
            $display("tb_fifo_page_replacement: FAIL");
            $finish;
        end
    end

    task automatic test_hits_and_evictions();
        send_reference(16'h0000, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h1234, 1'b0);
        send_reference(16'h8000, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h0001, 1'b0);
        send_reference(16'h0000, 1'b0);
        send_reference(16'h8000, 1'b1);
        send_reference(16'h8000, 1'b0);
    endtask

    task automatic test_frame_count_edges();
        set_frame_count(5'd0);
        send_reference(16'h5A5A, 1'b0);
        send_reference(16'h5A5A, 1'b0);
        send_reference(16'hA5A5, 1'b0);
        set_frame_count(5'd16);
        for (int k = 0; k < 10; k++) send_reference(16'h0100 + 16'(k), 1'b0);
        // stale pointer: lowered count leaves pointer beyond active frames
        set_frame_count(5'd3);
        send_reference(16'h7777, 1'b0);
        send_reference(16'h0109, 1'b0);
        // raise again: retained frames count, duplicate resolves to lowest frame
        set_frame_count(5'd17);
        send_reference(16'h0109, 1'b0);
        send_reference(16'h0107, 1'b0);
        set_frame_count(5'd31);
        send_reference(16'h0108, 1'b1);
    endtask

    task automatic test_random_strings(input int phases, input int per_phase);
        logic [PAGE_IN_W-1:0] page_pool[$];
        logic [CFG_W-1:0]     cfg_val;
        logic [PAGE_IN_W-1:0] pg;
        int                   n;
        for (int ph = 0; ph < phases; ph++) begin
            case (ph)
                0: cfg_val = 5'd1;
                1: cfg_val = 5'd2;
                2: cfg_val = 5'd4;
                3: cfg_val = 5'd16;
                4: cfg_val = 5'd0;
                5: cfg_val = 5'd31;
                default: cfg_val = CFG_W'($urandom_range(0, 31));
            endcase
            // idle-free final stretch
            if (ph == phases - 1) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            set_frame_count(cfg_val);
            n = (cfg_val == 0) ? 1 : (cfg_val > NUM_FRAMES ? NUM_FRAMES : cfg_val);
            page_pool.delete();
            repeat (n + $urandom_range(0, n + 2)) page_pool.push_back(16'($urandom));
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 4) == 0)
                    pg = 16'($urandom);
                else
                    pg = page_pool[$urandom_range(0, page_pool.size() - 1)];
                send_reference(pg, $urandom_range(0, 39) == 0);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_hits_and_evictions();
        test_frame_count_edges();
        test_random_strings(9, 195);
        wait_drained();
        $display("Ran %0d references, %0d results, %0d faults, %0d evictions,",
                 refs_sent, results_seen, faults_seen, evictions_seen);
        $display("over %0d frame-count writes including out-of-range counts and a stale pointer.",
                 cfg_writes);
        if (mismatch_count == 0) begin
            $display("tb_fifo_page_replacement: PASS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("tb_fifo_page_replacement: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fpr_pkg.sv
rtl/fpr_cell.sv
rtl/fifo_page_replacement.sv
tb/sv/tb_fifo_page_replacement.sv
